>>> design/lmbp_pkg.sv
`default_nettype none

package lmbp_pkg;

    localparam logic [31:0] LCG_MUL     = 32'd1103515245;
    localparam logic [31:0] LCG_ADD     = 32'd12345;
    localparam int          MIX_SHIFT   = 11;
    localparam int          QUEUE_DEPTH = 2;
    localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int          QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_DRAW   = 2'd0,
        OP_RESEED = 2'd1,
        OP_KEY    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] value;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW_ADD,
        ST_DRAW_MIX,
        ST_RS_ADD,
        ST_RS_MUL
    } back_state_t;

endpackage

`default_nettype wire

>>> design/lcg_mixed_byte_prng_top.sv
// Pseudo-random byte generator. A transaction is taken when start is high and busy is low;
// a two-entry command queue sits in front of the execution unit, so busy rises only when
// both entries are occupied. Each draw returns one byte on random_byte with byte_valid high
// for exactly one cycle, and the receiver cannot stall it. Reseed and key-mixing
// transactions produce no output. Execution is set by the single shared 32x32 multiplier
// and the add stage behind it: a draw from a held word and key mixing finish in the idle
// state, a draw that must generate a new word runs multiply, add and mix in turn, and a
// reseed runs four multiply/add pairs. A byte appears on the outputs in the cycle after it
// is computed. Each generated word yields four bytes. The unused operation code is accepted
// and discarded.
`default_nettype none

module lcg_mixed_byte_prng_top
    import lmbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] operand_value,
    output logic [7:0]       random_byte,
    output logic             byte_valid
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    lmbp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .operation     (operation),
        .operand_value (operand_value),
        .busy          (busy),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    lmbp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .random_byte (random_byte),
        .byte_valid  (byte_valid)
    );

endmodule

`default_nettype wire

>>> design/lmbp_front.sv
`default_nettype none

module lmbp_front
    import lmbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] operand_value,
    output logic             busy,
    output logic             cmd_valid,
    output cmd_t             cmd,
    input  wire logic        cmd_pop
);

    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              accept;
    logic              push;
    op_t               op_in;

    assign op_in     = op_t'(operation);
    assign busy      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign accept    = start && !busy;
    // unused opcode is swallowed here; it has no effect downstream
    assign push      = accept && (op_in != OP_NONE);
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= '{op: op_in, value: operand_value};
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("pop from empty queue");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !cmd_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push lost");

endmodule

`default_nettype wire

>>> design/lmbp_back.sv
`default_nettype none

module lmbp_back
    import lmbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    input  wire cmd_t        cmd,
    output logic             cmd_pop,
    output logic [7:0]       random_byte,
    output logic             byte_valid
);

    back_state_t state_reg, state_next;

    logic [31:0] mix_reg [4];
    logic [31:0] mix_next [4];
    logic [31:0] lcg_reg, lcg_next;
    logic [31:0] held_reg, held_next;
    logic [2:0]  bytes_left_reg, bytes_left_next;
    logic [31:0] prod_reg, prod_next;
    logic [1:0]  sel_reg, sel_next;
    logic [31:0] seed_reg, seed_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [7:0]  byte_reg, byte_next;
    logic        valid_reg, valid_next;

    logic [31:0] mul_lo;
    logic [31:0] lcg_new;
    logic [31:0] word;
    logic [1:0]  key_idx;

    // single shared multiplier, low 32 bits only
    assign mul_lo  = 32'(lcg_reg * LCG_MUL);
    assign lcg_new = prod_reg + LCG_ADD;
    assign word    = lcg_reg ^ mix_reg[sel_reg ^ 2'd3];
    assign key_idx = cmd.value[1:0] ^ mix_reg[cmd.value[1:0]][1:0];

    assign cmd_pop     = (state_reg == ST_IDLE) && cmd_valid;
    assign random_byte = byte_reg;
    assign byte_valid  = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == OP_DRAW && bytes_left_reg == 3'd0)
                    begin
                        state_next = ST_DRAW_ADD;
                    end
                    else if (cmd.op == OP_RESEED)
                    begin
                        state_next = ST_RS_ADD;
                    end
                end
            end
            ST_DRAW_ADD: state_next = ST_DRAW_MIX;
            ST_DRAW_MIX: state_next = ST_IDLE;
            ST_RS_ADD:   state_next = (cnt_reg == 2'd3) ? ST_IDLE : ST_RS_MUL;
            ST_RS_MUL:   state_next = ST_RS_ADD;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mix_next        = mix_reg;
        lcg_next        = lcg_reg;
        held_next       = held_reg;
        bytes_left_next = bytes_left_reg;
        prod_next       = prod_reg;
        sel_next        = sel_reg;
        seed_next       = seed_reg;
        cnt_next        = cnt_reg;
        byte_next       = byte_reg;
        valid_next      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_DRAW:
                        begin
                            if (bytes_left_reg != 3'd0)
                            begin
                                byte_next       = held_reg[7:0];
                                valid_next      = 1'b1;
                                held_next       = {8'h00, held_reg[31:8]};
                                bytes_left_next = bytes_left_reg - 3'd1;
                            end
                            else
                            begin
                                prod_next = mul_lo;
                                sel_next  = mix_reg[lcg_reg[1:0]][1:0];
                            end
                        end
                        OP_RESEED:
                        begin
                            prod_next = mul_lo;
                            seed_next = cmd.value;
                            cnt_next  = 2'd0;
                        end
                        OP_KEY:
                        begin
                            mix_next[key_idx] = mix_reg[key_idx] ^ {2'b00, cmd.value[31:2]};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DRAW_ADD:
            begin
                lcg_next          = lcg_new;
                mix_next[sel_reg] = mix_reg[sel_reg] ^ lcg_new;
            end
            ST_DRAW_MIX:
            begin
                mix_next[sel_reg ^ 2'd1] = mix_reg[sel_reg ^ 2'd1]
                    + (mix_reg[sel_reg ^ 2'd2] ^ (lcg_reg << MIX_SHIFT));
                byte_next       = word[7:0];
                valid_next      = 1'b1;
                held_next       = {8'h00, word[31:8]};
                bytes_left_next = 3'd3;
            end
            ST_RS_ADD:
            begin
                lcg_next          = lcg_new;
                mix_next[cnt_reg] = {24'h000000, seed_reg[7:0]} ^ lcg_new;
                seed_next         = {8'h00, seed_reg[31:8]};
                cnt_next          = cnt_reg + 2'd1;
            end
            ST_RS_MUL:
            begin
                prod_next = mul_lo;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mix_reg        <= '{default: '0};
            lcg_reg        <= '0;
            held_reg       <= '0;
            bytes_left_reg <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mix_reg        <= mix_next;
            lcg_reg        <= lcg_next;
            held_reg       <= held_next;
            bytes_left_reg <= bytes_left_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sel_reg  <= sel_next;
        seed_reg <= seed_next;
        cnt_reg  <= cnt_next;
        byte_reg <= byte_next;
    end

    a_draw_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW_ADD) |=> (state_reg == ST_DRAW_MIX))
        else $error("draw sequence broken");

    a_draw_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW_MIX) |=> (valid_reg && bytes_left_reg == 3'd3))
        else $error("generated word not delivered");

    a_reseed_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RS_ADD && cnt_reg == 2'd3) |=> (state_reg == ST_IDLE))
        else $error("reseed did not finish after four steps");

    a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_left_reg <= 3'd3)
        else $error("byte count out of range");

endmodule

`default_nettype wire

>>> tb/lcg_mixed_byte_prng_top_test.sv
`timescale 1ns / 1ps

module lcg_mixed_byte_prng_top_test;
    import lmbp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_TAIL   = 150;
    localparam int SETTLE       = 64;
    localparam int MAX_PRINTS   = 100;

    // Tracks generator state and the bytes that draws still owe.
    class draw_byte_tracker;
        logic [31:0] mix_word [4];
        logic [31:0] lcg;
        logic [31:0] held;
        logic [2:0]  left;
        logic [7:0]  pending_bytes [$];
        int          mismatches;

        function new();
            for (int i = 0; i < 4; i++)
            begin
                mix_word[i] = '0;
            end
            lcg        = '0;
            held       = '0;
            left       = '0;
            mismatches = 0;
        endfunction

        function void step_lcg();
            lcg = lcg * LCG_MUL + LCG_ADD;
        endfunction

        function logic [31:0] next_word();
            logic [1:0] s;
            s = mix_word[lcg[1:0]][1:0];
            step_lcg();
            mix_word[s] ^= lcg;
            mix_word[s ^ 2'd1] += mix_word[s ^ 2'd2] ^ (lcg << MIX_SHIFT);
            return lcg ^ mix_word[s ^ 2'd3];
        endfunction

        function void take_command(op_t op, logic [31:0] value);
            logic [1:0]  idx;
            logic [31:0] v;
            v = value;
            case (op)
                OP_DRAW:
                begin
                    if (left == 3'd0)
                    begin
                        held = next_word();
                        left = 3'd4;
                    end
                    pending_bytes.push_back(held[7:0]);
                    held = held >> 8;
                    left = left - 3'd1;
                end
                OP_RESEED:
                begin
                    // keeps stepping from the current LCG value
                    for (int i = 0; i < 4; i++)
                    begin
                        step_lcg();
                        mix_word[i] = {24'd0, v[7:0]} ^ lcg;
                        v = v >> 8;
                    end
                end
                OP_KEY:
                begin
                    idx = v[1:0] ^ mix_word[v[1:0]][1:0];
                    mix_word[idx] ^= v >> 2;
                end
                default:
                begin
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check_byte(logic [7:0] got);
            logic [7:0] want;
            if (pending_bytes.size() == 0)
            begin
                report_mismatch($sformatf("byte %02h with no draw outstanding", got));
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("random_byte %02h, expected %02h", got, want));
            end
        endtask
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        start         = 1'b0;
    logic [1:0]  operation     = OP_DRAW;
    logic [31:0] operand_value = '0;
    logic        busy;
    logic [7:0]  random_byte;
    logic        byte_valid;
    int          cycles        = 0;

    draw_byte_tracker tracker;

    lcg_mixed_byte_prng_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .operand_value (operand_value),
        .random_byte   (random_byte),
        .byte_valid    (byte_valid)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && byte_valid)
            tracker.check_byte(random_byte);
    end

    // Holds start high until the transaction is taken.
    task send_cmd(input op_t op, input logic [31:0] value);
        start         <= 1'b1;
        operation     <= op;
        operand_value <= value;
        do @(posedge clk); while (busy);
        tracker.take_command(op, value);
    endtask

    task idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task maybe_idle(input bit allow);
        if (allow && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 11));
    endtask

    task drain();
        start <= 1'b0;
        while (tracker.pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    function logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function op_t pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return OP_DRAW;
        else if (r < 72)
            return OP_RESEED;
        else if (r < 92)
            return OP_KEY;
        else
            return OP_NONE;
    endfunction

    initial
    begin
        tracker = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // draws from the reset state, crossing a word boundary
        repeat (5) send_cmd(OP_DRAW, $urandom);
        send_cmd(OP_KEY, 32'h0000_0000);
        send_cmd(OP_KEY, 32'hFFFF_FFFF);
        send_cmd(OP_DRAW, 32'hFFFF_FFFF);
        send_cmd(OP_RESEED, 32'h0000_0000);
        repeat (2) send_cmd(OP_DRAW, 32'h0000_0000);
        // back-to-back reseeds chain the LCG
        send_cmd(OP_RESEED, 32'hFFFF_FFFF);
        send_cmd(OP_RESEED, $urandom);
        repeat (4) send_cmd(OP_DRAW, $urandom);
        send_cmd(OP_NONE, $urandom);
        send_cmd(OP_DRAW, $urandom);
        for (int k = 0; k < 4; k++)
        begin
            send_cmd(OP_KEY, {30'($urandom_range(0, 32'h3FFF_FFFF)), 2'(k)});
            maybe_idle(1'b1);
        end
        repeat (2) send_cmd(OP_DRAW, $urandom);
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                drain();
            send_cmd(pick_op(), pick_value());
            maybe_idle(n < RANDOM_ITEMS - QUIET_TAIL);
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
